/* src/tdt_pkg.sv */
// ----------------------------------------------------------------------------
// tdt_pkg
// Shared types, constants and compare functions for the tuple dedup table.
// ----------------------------------------------------------------------------
package tdt_pkg;

    // table geometry
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int CFG_W  = 11;

    // configuration register indexes
    localparam logic CFG_SEARCH_WINDOW = 1'b0;
    localparam logic CFG_TABLE_LIMIT   = 1'b1;

    // outcome codes
    localparam logic [1:0] OUT_FOUND   = 2'd0;
    localparam logic [1:0] OUT_ADDED   = 2'd1;
    localparam logic [1:0] OUT_REFUSED = 2'd2;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(1024);
    localparam logic [CFG_W-1:0] LIMIT_RESET  = CFG_W'(1024);

    typedef struct packed {
        logic [31:0] value_a;
        logic [31:0] value_b;
        logic [31:0] value_c;
        logic [31:0] value_d;
        logic [31:0] value_e;
    } t_in_item;

    typedef struct packed {
        logic [9:0] entry_index;
        logic [1:0] outcome;
        logic       table_full;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic skip;
        logic hit;
        logic search_done;
        logic out_free;
    } t_status;

    // ieee single equality: signed zeros match, nan never matches
    function automatic logic float_eq(input logic [31:0] x, input logic [31:0] y);
        logic x_nan;
        logic y_nan;
        x_nan = (x[30:0] > 31'h7F80_0000);
        y_nan = (y[30:0] > 31'h7F80_0000);
        if (x_nan || y_nan) begin
            return 1'b0;
        end else if ((x[30:0] | y[30:0]) == 31'd0) begin
            return 1'b1;
        end else begin
            return (x == y);
        end
    endfunction

    function automatic logic tuple_eq(input t_in_item t, input t_in_item v);
        return float_eq(t.value_a, v.value_a) && float_eq(t.value_b, v.value_b) &&
               float_eq(t.value_c, v.value_c) && float_eq(t.value_d, v.value_d) &&
               float_eq(t.value_e, v.value_e);
    endfunction

endpackage

/* src/tuple_dedup_table_top.sv */
// ----------------------------------------------------------------------------
// tuple_dedup_table_top
// Deduplicating table of five-float tuples with a bounded backward search.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one tuple per transaction.
// Output channel: o_out_valid / i_out_stall carry the entry index, outcome
// (found, added, refused) and the table full flag.
// Configuration: i_cfg_we writes i_cfg_data into the register selected by
// i_cfg_index (0 search window, 1 table limit); write only while idle.
// Search: an item is compared with up to span stored tuples, span being
// min(search window, entry count); an item with nothing to search (refused,
// empty table or zero window) skips the search. The search reads one stored
// tuple per cycle from the single read port of the tuple memory, newest
// first, and stops on a match.
// One item is in work at a time; the next is accepted once the result is in
// the output register, so a waiting result does not block the input.
// Reset clears the entry count, the full flag, the configuration (both 1024)
// and the output valid; the tuple memory is not cleared, since only written
// entries are ever searched. While i_out_stall is high a valid result holds
// and a finished search waits before committing its result.
// ----------------------------------------------------------------------------
module tuple_dedup_table_top import tdt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    tdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // memory, comparator and result register
    tdt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

/* src/tdt_ctrl.sv */
// ----------------------------------------------------------------------------
// tdt_ctrl
// Sequencer: accepts a transaction, steps the backward search, commits result.
// ----------------------------------------------------------------------------
module tdt_ctrl import tdt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.skip ? S_FINISH : S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_status.hit || i_status.search_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/tdt_dpath.sv */
// ----------------------------------------------------------------------------
// tdt_dpath
// Tuple memory, search address counter, comparator, entry count and result
// register.
// ----------------------------------------------------------------------------
module tdt_dpath import tdt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  t_cmd             i_cmd,
    output t_status          o_status
);

    t_in_item          mem [DEPTH];

    logic [CFG_W-1:0]  r_window;
    logic [CFG_W-1:0]  r_limit;
    logic [CNT_W-1:0]  r_count;
    logic              r_full;

    t_in_item          r_tuple;
    t_in_item          r_rd;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_cmp_addr;
    logic [CNT_W-1:0]  r_remain;
    logic              r_pend;
    logic [1:0]        r_outcome;
    logic [ADDR_W-1:0] r_idx;

    logic              r_out_valid;
    t_out_item         r_out;

    logic [CNT_W-1:0]  span;
    logic              hit;
    logic              added;
    logic [CNT_W-1:0]  n_count;
    logic              n_full;
    logic              out_free;

    // search span and compare against the registered memory word
    assign span     = (r_window < r_count) ? r_window : r_count;
    assign hit      = r_pend && tuple_eq(r_rd, r_tuple);
    assign out_free = !r_out_valid || !i_out_stall;

    // count and full flag after commit
    assign added   = (r_outcome == OUT_ADDED);
    assign n_count = r_count + CNT_W'(added);
    assign n_full  = r_full || (n_count >= r_limit) || (n_count >= CNT_W'(DEPTH));

    assign o_status.skip        = r_full || (span == '0);
    assign o_status.hit         = hit;
    assign o_status.search_done = !r_pend && (r_remain == '0);
    assign o_status.out_free    = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_limit  <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEARCH_WINDOW: r_window <= i_cfg_data;
                CFG_TABLE_LIMIT:   r_limit  <= i_cfg_data;
                default:           r_window <= r_window;
            endcase
        end
    end

    // tuple memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && added) begin
            mem[r_count[ADDR_W-1:0]] <= r_tuple;
        end
        if (i_cmd.step && (r_remain != '0)) begin
            r_rd <= mem[r_addr];
        end
    end

    // search control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_cmd.load) begin
            r_pend <= 1'b0;
        end else if (i_cmd.step) begin
            r_pend <= (r_remain != '0);
        end
    end

    // search payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tuple   <= i_in_data;
            r_outcome <= r_full ? OUT_REFUSED : OUT_ADDED;
            r_addr    <= ADDR_W'(r_count - CNT_W'(1));
            r_remain  <= span;
        end else if (i_cmd.step) begin
            if (r_remain != '0) begin
                r_cmp_addr <= r_addr;
                r_addr     <= r_addr - ADDR_W'(1);
                r_remain   <= r_remain - CNT_W'(1);
            end
            if (hit) begin
                r_outcome <= OUT_FOUND;
                r_idx     <= r_cmp_addr;
            end
        end
    end

    // entry count and sticky full flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_full  <= 1'b0;
        end else if (i_cmd.finish) begin
            r_count <= n_count;
            r_full  <= n_full;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.outcome    <= r_outcome;
            r_out.table_full <= n_full;
            case (r_outcome)
                OUT_FOUND: r_out.entry_index <= 10'(r_idx);
                OUT_ADDED: r_out.entry_index <= 10'(r_count[ADDR_W-1:0]);
                default:   r_out.entry_index <= '0;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("full flag cleared without reset");

    a_add_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && added) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("added entry did not advance the count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_out_valid) |-> !i_out_stall)
        else $error("result register overwritten while stalled");

    a_refuse_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && (r_outcome == OUT_REFUSED)) |-> r_full)
        else $error("transaction refused while table not full");
`endif

endmodule

/* sim/tuple_dedup_table_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuple_dedup_table_top_test
// Self-checking testbench for the tuple dedup table. A directed table covers
// float equality corners (signed zeros, NaN, infinities, denormals), then
// random phases with repeated and mutated tuples run under several search
// window and table limit settings; the last phases fill the table and check that
// later tuples are refused. Results are checked by a predictor or directed rows.
// ----------------------------------------------------------------------------
module tuple_dedup_table_top_test;
    import tdt_pkg::*;

    localparam int N_DIRECTED  = 23;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 1100;

    typedef struct packed {
        t_in_item  tuple;
        logic      fixed_exp;
        t_out_item expected;
    } t_row;

    // dut inputs, all known from time zero
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic                 cfg_index  = CFG_SEARCH_WINDOW;
    logic [CFG_W-1:0]     cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    t_in_item             in_data    = '0;
    logic                 out_stall  = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_item            o_out_data;

    // predictor state
    t_in_item             shadow_store [DEPTH];
    int unsigned          shadow_count  = 0;
    bit                   shadow_full   = 1'b0;
    logic [CFG_W-1:0]     shadow_window = WINDOW_RESET;
    logic [CFG_W-1:0]     shadow_limit  = LIMIT_RESET;

    // results still owed by the block, oldest first
    t_out_item            lookup_results_due [$];
    t_in_item             sent_tuples [$];
    t_row                 directed_rows [N_DIRECTED];

    bit                   cur_fixed_exp = 1'b0;
    t_out_item            cur_expected  = '0;
    bit                   src_idle  = 1'b1;
    bit                   sink_idle = 1'b1;
    bit                   hold_req  = 1'b0;
    int unsigned          failures  = 0;
    int unsigned          cycle_count = 0;
    int unsigned          n_sent = 0;
    int unsigned          n_found = 0;
    int unsigned          n_added = 0;
    int unsigned          n_refused = 0;

    tuple_dedup_table_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, lookup_results_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ieee single equality: a nan has an all-ones exponent and a nonzero fraction
    function automatic bit same_float(logic [31:0] x, logic [31:0] y);
        bit x_nan;
        bit y_nan;
        x_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        y_nan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
        if (x_nan || y_nan)
            return 1'b0;
        if (x[30:0] == 31'd0 && y[30:0] == 31'd0)
            return 1'b1;
        return x == y;
    endfunction

    function automatic bit same_tuple(t_in_item p, t_in_item q);
        logic [4:0][31:0] pw;
        logic [4:0][31:0] qw;
        pw = p;
        qw = q;
        for (int k = 0; k < 5; k++) begin
            if (!same_float(pw[k], qw[k]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // predicted result of one tuple; updates the shadow table
    function automatic t_out_item lookup_or_insert(t_in_item v);
        t_out_item   r;
        int unsigned span;
        int unsigned pos;
        bit          hit;
        r = '0;
        if (shadow_full) begin
            r.outcome    = OUT_REFUSED;
            r.table_full = 1'b1;
            return r;
        end
        span = (shadow_window < shadow_count) ? shadow_window : shadow_count;
        hit  = 1'b0;
        // newest first, stop on the first match
        for (int k = 1; k <= span; k++) begin
            pos = shadow_count - k;
            if (pos < DEPTH && same_tuple(shadow_store[pos], v)) begin
                hit = 1'b1;
                r.entry_index = 10'(pos);
                break;
            end
        end
        if (hit) begin
            r.outcome = OUT_FOUND;
        end else begin
            pos = shadow_count;
            if (pos < DEPTH) begin
                shadow_store[pos] = v;
                shadow_count++;
            end
            r.entry_index = 10'(pos);
            r.outcome     = OUT_ADDED;
        end
        if (shadow_count >= shadow_limit || shadow_count >= DEPTH)
            shadow_full = 1'b1;
        r.table_full = shadow_full;
        return r;
    endfunction

    function automatic t_in_item tuple5(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                        logic [31:0] d, logic [31:0] e);
        t_in_item t;
        t.value_a = a;
        t.value_b = b;
        t.value_c = c;
        t.value_d = d;
        t.value_e = e;
        return t;
    endfunction

    function automatic t_in_item uniform(logic [31:0] v);
        return tuple5(v, v, v, v, v);
    endfunction

    function automatic t_row mk_row(t_in_item t, bit fixed_exp, int unsigned idx,
                                    logic [1:0] oc);
        t_row r;
        r.tuple                = t;
        r.fixed_exp            = fixed_exp;
        r.expected.entry_index = 10'(idx);
        r.expected.outcome     = oc;
        r.expected.table_full  = 1'b0;
        return r;
    endfunction

    // field values that sit on the edges of float equality
    function automatic logic [31:0] special_value(int unsigned k);
        case (k)
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h7F80_0000;
            3:       return 32'hFF80_0000;
            4:       return 32'h7FC0_0000;
            5:       return 32'hFFFF_FFFF;
            6:       return 32'h7F80_0001;
            7:       return 32'h0000_0001;
            8:       return 32'h7F7F_FFFF;
            default: return 32'h3F80_0000;
        endcase
    endfunction

    function automatic logic [31:0] random_field();
        case ($urandom_range(0, 9))
            0, 1:    return special_value($urandom_range(0, 9));
            2:       return 32'h3F80_0000 + ($urandom_range(0, 3) << 23);
            default: return $urandom();
        endcase
    endfunction

    // mostly repeats of earlier tuples, often recent ones, some mutated, the rest fresh
    function automatic t_in_item next_tuple();
        logic [4:0][31:0] w;
        int unsigned      r;
        int unsigned      n;
        int unsigned      k;
        r = $urandom_range(0, 99);
        n = sent_tuples.size();
        if (r < 55 && n > 0) begin
            if (r < 40)
                w = sent_tuples[n - 1 - $urandom_range(0, (n < 12 ? n : 12) - 1)];
            else
                w = sent_tuples[$urandom_range(0, n - 1)];
            k = $urandom_range(0, 4);
            case ($urandom_range(0, 9))
                0:       w[k][31] = ~w[k][31];
                1:       w[k] = 32'h7FC0_0000 | $urandom_range(0, 255);
                2:       w[k] = random_field();
                default: ;
            endcase
        end else begin
            for (int j = 0; j < 5; j++)
                w[j] = random_field();
        end
        return w;
    endfunction

    // offer one tuple; caller is at a falling edge, returns at a falling edge
    task automatic push_tuple(t_in_item t, bit fixed_exp, t_out_item expected);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid      <= 1'b1;
        in_data       <= t;
        cur_fixed_exp  = fixed_exp;
        cur_expected   = expected;
        sent_tuples.push_back(t);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic run_random(int unsigned n);
        for (int unsigned j = 0; j < n; j++)
            push_tuple(next_tuple(), 1'b0, '0);
    endtask

    // drain the block, then write both registers while it is idle
    task automatic set_phase(logic [CFG_W-1:0] window, logic [CFG_W-1:0] limit);
        in_valid <= 1'b0;
        while (lookup_results_due.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SEARCH_WINDOW;
        cfg_data  <= window;
        @(negedge i_clk);
        cfg_index <= CFG_TABLE_LIMIT;
        cfg_data  <= limit;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic void report_mismatch(string what, t_out_item want, t_out_item got);
        failures++;
        if (failures <= 10)
            $display("%0t: %s: expected index %0d outcome %0d full %0d, got %0d %0d %0d",
                     $realtime, what, want.entry_index, want.outcome, want.table_full,
                     got.entry_index, got.outcome, got.table_full);
    endfunction

    // transaction monitor: predict on input, check on output
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (cfg_we) begin
                if (cfg_index == CFG_SEARCH_WINDOW)
                    shadow_window = cfg_data;
                else
                    shadow_limit = cfg_data;
            end
            if (in_valid && !o_in_stall) begin
                want = lookup_or_insert(in_data);
                if (cur_fixed_exp)
                    want = cur_expected;
                lookup_results_due.push_back(want);
            end
            if (o_out_valid && !out_stall) begin
                case (o_out_data.outcome)
                    OUT_FOUND: n_found++;
                    OUT_ADDED: n_added++;
                    default:   n_refused++;
                endcase
                if (lookup_results_due.size() == 0) begin
                    report_mismatch("result with none pending", '0, o_out_data);
                end else begin
                    want = lookup_results_due.pop_front();
                    if (o_out_data.entry_index !== want.entry_index ||
                        o_out_data.outcome !== want.outcome ||
                        o_out_data.table_full !== want.table_full)
                        report_mismatch("result mismatch", want, o_out_data);
                end
            end
        end
    end

    // result side: random stalls, plus one long hold on request
    initial begin
        int unsigned gap;
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                gap      = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                gap = sink_idle ? $urandom_range(0, 6) : 0;
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // stimulus
    initial begin
        // directed corners under reset settings
        directed_rows[0]  = mk_row(uniform(32'h0000_0000), 1, 0, OUT_ADDED);
        directed_rows[1]  = mk_row(uniform(32'h8000_0000), 1, 0, OUT_FOUND);
        directed_rows[2]  = mk_row(tuple5(32'h0, 32'h8000_0000, 32'h0, 32'h8000_0000,
                                          32'h0), 1, 0, OUT_FOUND);
        directed_rows[3]  = mk_row(uniform(32'hFFFF_FFFF), 1, 1, OUT_ADDED);
        directed_rows[4]  = mk_row(uniform(32'hFFFF_FFFF), 1, 2, OUT_ADDED);
        directed_rows[5]  = mk_row(uniform(32'h7F80_0000), 1, 3, OUT_ADDED);
        directed_rows[6]  = mk_row(uniform(32'hFF80_0000), 1, 4, OUT_ADDED);
        directed_rows[7]  = mk_row(uniform(32'h7F80_0000), 1, 3, OUT_FOUND);
        directed_rows[8]  = mk_row(uniform(32'h7F80_0001), 1, 5, OUT_ADDED);
        directed_rows[9]  = mk_row(uniform(32'h7FFF_FFFF), 1, 6, OUT_ADDED);
        directed_rows[10] = mk_row(uniform(32'h0000_0001), 1, 7, OUT_ADDED);
        directed_rows[11] = mk_row(uniform(32'h8000_0001), 1, 8, OUT_ADDED);
        directed_rows[12] = mk_row(uniform(32'h7F7F_FFFF), 1, 9, OUT_ADDED);
        directed_rows[13] = mk_row(uniform(32'hFF7F_FFFF), 1, 10, OUT_ADDED);
        directed_rows[14] = mk_row(tuple5(32'h3F80_0000, 32'h3F80_0000, 32'h7FC0_0000,
                                          32'h3F80_0000, 32'h3F80_0000), 1, 11, OUT_ADDED);
        directed_rows[15] = mk_row(tuple5(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF,
                                          32'h7F7F_FFFF, 32'h7F7F_FFFE), 1, 12, OUT_ADDED);
        directed_rows[16] = mk_row(uniform(32'h7F7F_FFFF), 1, 9, OUT_FOUND);
        directed_rows[17] = mk_row(uniform(32'h0000_0001), 1, 7, OUT_FOUND);
        directed_rows[18] = mk_row(tuple5(32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000,
                                          32'h7F80_0000, 32'h0), 1, 13, OUT_ADDED);
        directed_rows[19] = mk_row(tuple5(32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000,
                                          32'h7F80_0000, 32'h8000_0000), 1, 13, OUT_FOUND);
        directed_rows[20] = mk_row(tuple5(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                          32'hAAAA_AAAA, 32'h5555_5555), 0, 0, OUT_ADDED);
        directed_rows[21] = mk_row(tuple5(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                          32'h5555_5555, 32'hAAAA_AAAA), 0, 0, OUT_ADDED);
        directed_rows[22] = mk_row(directed_rows[14].tuple, 0, 0, OUT_ADDED);

        // reset
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++)
            push_tuple(directed_rows[r].tuple, directed_rows[r].fixed_exp,
                       directed_rows[r].expected);

        // narrowest windows: one entry, then none
        set_phase(11'd1, 11'd2047);
        run_random(60);
        set_phase(11'd0, 11'd2047);
        run_random(40);

        // small window with a long hold on the result side
        set_phase(11'd4, 11'd2047);
        hold_req = 1'b1;
        run_random(80);

        // widest window, no idling on either side
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        set_phase(11'd2047, 11'd2047);
        run_random(100);

        src_idle  = 1'b1;
        sink_idle = 1'b1;
        set_phase(CFG_W'($urandom_range(5, 64)), LIMIT_RESET);
        run_random(100);

        sink_idle = 1'b0;
        set_phase(WINDOW_RESET, LIMIT_RESET);
        run_random(100);

        // fill the table a few entries past the current count
        sink_idle = 1'b1;
        set_phase(CFG_W'($urandom_range(1, 16)), CFG_W'(shadow_count + 4));
        run_random(60);

        // full flag stays set when the limit is raised, and with a zero limit
        set_phase(11'd8, 11'd2047);
        run_random(20);
        set_phase(11'd1, 11'd0);
        run_random(20);

        // drain and let any stray result show up
        in_valid <= 1'b0;
        while (lookup_results_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("sent %0d tuples in %0d cycles: %0d found, %0d added, %0d refused",
                 n_sent, cycle_count, n_found, n_added, n_refused);
        $display("windows 0 to 2047, limits 0 to 2047, table count reached %0d",
                 shadow_count);
        if (failures == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d failures", failures);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
